@@ rtl/core/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, letter codes and square arithmetic for the Playfair core.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int LETTER_W  = 5;
    localparam int SLOT_W    = 5;
    localparam int SQ_SIDE   = 5;
    localparam int SQ_CELLS  = SQ_SIDE * SQ_SIDE;

    localparam logic [LETTER_W-1:0] LETTER_I      = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J      = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X      = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_Z      = 5'd25;
    localparam logic [SLOT_W-1:0]   FULL_COUNT    = SLOT_W'(SQ_CELLS);
    localparam logic [LETTER_W-1:0] FILLER_RESET  = LETTER_X;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_KEY      = 3'd1,
        OP_COMPLETE = 3'd2,
        OP_ENCRYPT  = 3'd3,
        OP_DECRYPT  = 3'd4
    } op_t;

    // one letter placed into the square
    typedef struct packed {
        logic                valid;
        logic [SLOT_W-1:0]   slot;
        logic [LETTER_W-1:0] letter;
    } sq_write_t;

    // pair to transform
    typedef struct packed {
        logic                valid;
        logic                decrypt;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
    } sq_req_t;

    typedef struct packed {
        logic                valid;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
    } sq_res_t;

    // slot / 5 for slots 0..24: (slot * 13) >> 6
    function automatic logic [2:0] slot_row(input logic [SLOT_W-1:0] slot);
        logic [8:0] prod;
        prod = {4'b0, slot} * 9'd13;
        return prod[8:6];
    endfunction

    function automatic logic [2:0] slot_col(input logic [SLOT_W-1:0] slot);
        logic [2:0]        row;
        logic [SLOT_W-1:0] diff;
        row  = slot_row(slot);
        diff = slot - {row, 2'b00} - {2'b00, row};
        return diff[2:0];
    endfunction

    function automatic logic [2:0] step_mod5(input logic [2:0] v, input logic down);
        logic [2:0] r;
        if (down)
        begin
            r = (v == 3'd0) ? 3'd4 : v - 3'd1;
        end
        else
        begin
            r = (v == 3'd4) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [2:0] row,
                                                  input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

endpackage

@@ rtl/core/pfc_square.sv @@
// ----------------------------------------------------------------------------
// pfc_square
// Key square and letter-position memories with a two-read lookup pipeline:
// positions are read first, then the two output letters of the square.
// ----------------------------------------------------------------------------
module pfc_square
    import pfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sq_write_t wr,
    input  sq_req_t   req,
    output sq_res_t   res
);

    logic [LETTER_W-1:0] sq_mem  [SQ_CELLS];
    logic [SLOT_W-1:0]   pos_mem [LETTER_Z + 1];

    logic [SLOT_W-1:0]   pos_a_reg;
    logic [SLOT_W-1:0]   pos_b_reg;
    logic                dec_reg;
    logic                s1_valid_reg;
    logic                s2_valid_reg;
    logic [LETTER_W-1:0] out_a_reg;
    logic [LETTER_W-1:0] out_b_reg;

    logic [2:0]          r1, c1, r2, c2;
    logic [2:0]          r1_n, c1_n, r2_n, c2_n;
    logic [SLOT_W-1:0]   addr_a, addr_b;

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            sq_mem[wr.slot]    <= wr.letter;
            pos_mem[wr.letter] <= wr.slot;
        end
    end

    // stage 1: slot of each letter
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            pos_a_reg <= pos_mem[req.first];
            pos_b_reg <= pos_mem[req.second];
            dec_reg   <= req.decrypt;
        end
    end

    always_comb
    begin
        r1 = slot_row(pos_a_reg);
        c1 = slot_col(pos_a_reg);
        r2 = slot_row(pos_b_reg);
        c2 = slot_col(pos_b_reg);
        priority if (r1 == r2)
        begin
            r1_n = r1;
            r2_n = r2;
            c1_n = step_mod5(c1, dec_reg);
            c2_n = step_mod5(c2, dec_reg);
        end
        else if (c1 == c2)
        begin
            r1_n = step_mod5(r1, dec_reg);
            r2_n = step_mod5(r2, dec_reg);
            c1_n = c1;
            c2_n = c2;
        end
        else
        begin
            r1_n = r1;
            r2_n = r2;
            c1_n = c2;
            c2_n = c1;
        end
        addr_a = slot_of(r1_n, c1_n);
        addr_b = slot_of(r2_n, c2_n);
    end

    // stage 2: letters of the transformed pair; held until the next lookup
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            out_a_reg <= sq_mem[addr_a];
            out_b_reg <= sq_mem[addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign res.valid  = s2_valid_reg;
    assign res.first  = out_a_reg;
    assign res.second = out_b_reg;

endmodule

@@ rtl/core/playfair_digraph_cipher_core.sv @@
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_core
// Playfair cipher on letter indices with streaming input, output and a
// filler-letter register.
// ----------------------------------------------------------------------------
// Clear and key-letter beats leave tready high. Complete-key walks
// over the 26 letters, one per cycle, filling the square, with tready
// low. A text letter that only becomes pending leaves tready high. A
// letter that produces a pair holds tready low for the chained
// position read and square read of the key memories. The result then
// sits in the output register while the next beat is taken. An unpaired
// final ciphertext letter skips the square reads. A result that finds
// the output register still busy holds the input until the register
// frees up. Encrypt pads doubled letters and odd tails with the filler;
// decrypt flags an unpaired final letter with tuser set and zero data.
// Text is ignored until the square is complete.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_core
    import pfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] operation
    input  logic        s_axis_tlast,   // last_letter

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] first_out, [9:5] second_out, [15:10] zero
    output logic [0:0]  m_axis_tuser,   // [0] status
    output logic        m_axis_tlast,   // last_of_run

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data        // filler_letter
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FILL = 4'b0010,
        ST_LOOK = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [LETTER_W-1:0] filler_reg;
    logic [LETTER_Z:0]   used_reg, used_next;
    logic [SLOT_W-1:0]   fill_count_reg, fill_count_next;
    logic [LETTER_W-1:0] walk_reg, walk_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [LETTER_W-1:0] pend_letter_reg, pend_letter_next;
    logic                res_twice_reg, res_twice_next;
    logic                res_status_reg, res_status_next;

    logic                out_valid_reg;
    logic                out_last_reg;
    logic [LETTER_W-1:0] out_a_reg;
    logic [LETTER_W-1:0] out_b_reg;
    logic                out_status_reg;

    logic                accept;
    op_t                 op;
    logic [LETTER_W-1:0] in_letter;
    logic [LETTER_W-1:0] txt_letter;
    logic [LETTER_W-1:0] fill_letter;
    logic [LETTER_W-1:0] place_letter;
    logic                place_try;
    logic                text_ok;
    logic                out_free;
    logic                load;
    sq_write_t           sq_wr;
    sq_req_t             sq_req;
    sq_res_t             sq_res;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = op_t'(s_axis_tuser);
    assign in_letter     = s_axis_tdata[LETTER_W-1:0];

    assign txt_letter  = (in_letter == LETTER_J) ? LETTER_I : in_letter;
    always_comb
    begin
        if (filler_reg > LETTER_Z)
        begin
            fill_letter = LETTER_Z;
        end
        else if (filler_reg == LETTER_J)
        begin
            fill_letter = LETTER_I;
        end
        else
        begin
            fill_letter = filler_reg;
        end
    end

    assign text_ok = (fill_count_reg == FULL_COUNT) && (in_letter <= LETTER_Z);

    // placement shared by key letters and the completion walk
    assign place_letter = (state_reg == ST_FILL) ? walk_reg : in_letter;
    assign place_try    = (state_reg == ST_FILL) || (accept && op == OP_KEY);

    always_comb
    begin
        sq_wr.valid  = place_try && (place_letter <= LETTER_Z)
                       && (place_letter != LETTER_J) && !used_reg[place_letter]
                       && (fill_count_reg < FULL_COUNT);
        sq_wr.slot   = fill_count_reg;
        sq_wr.letter = place_letter;
    end

    assign out_free = !out_valid_reg || (m_axis_tready && out_last_reg);

    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        fill_count_next  = fill_count_reg;
        walk_next        = walk_reg;
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        res_twice_next   = res_twice_reg;
        res_status_next  = res_status_reg;
        load             = 1'b0;
        sq_req.valid     = 1'b0;
        sq_req.decrypt   = (op == OP_DECRYPT);
        sq_req.first     = pend_letter_reg;
        sq_req.second    = txt_letter;

        if (sq_wr.valid)
        begin
            used_next[place_letter] = 1'b1;
            fill_count_next         = fill_count_reg + SLOT_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_CLEAR:
                        begin
                            used_next       = '0;
                            fill_count_next = '0;
                            pend_valid_next = 1'b0;
                        end
                        OP_KEY:
                        begin
                        end
                        OP_COMPLETE:
                        begin
                            walk_next  = '0;
                            state_next = ST_FILL;
                        end
                        OP_ENCRYPT:
                        begin
                            if (text_ok)
                            begin
                                res_status_next = 1'b0;
                                if (pend_valid_reg && pend_letter_reg != txt_letter)
                                begin
                                    sq_req.valid    = 1'b1;
                                    res_twice_next  = 1'b0;
                                    pend_valid_next = 1'b0;
                                    state_next      = ST_LOOK;
                                end
                                else if (pend_valid_reg)
                                begin
                                    // doubled letter: pair with filler, keep pending unless last
                                    sq_req.valid    = 1'b1;
                                    sq_req.second   = fill_letter;
                                    res_twice_next  = s_axis_tlast;
                                    pend_valid_next = !s_axis_tlast;
                                    state_next      = ST_LOOK;
                                end
                                else if (s_axis_tlast)
                                begin
                                    sq_req.valid   = 1'b1;
                                    sq_req.first   = txt_letter;
                                    sq_req.second  = fill_letter;
                                    res_twice_next = 1'b0;
                                    state_next     = ST_LOOK;
                                end
                                else
                                begin
                                    pend_valid_next  = 1'b1;
                                    pend_letter_next = txt_letter;
                                end
                            end
                        end
                        OP_DECRYPT:
                        begin
                            if (text_ok)
                            begin
                                res_twice_next = 1'b0;
                                if (pend_valid_reg)
                                begin
                                    sq_req.valid    = 1'b1;
                                    res_status_next = 1'b0;
                                    pend_valid_next = 1'b0;
                                    state_next      = ST_LOOK;
                                end
                                else if (s_axis_tlast)
                                begin
                                    res_status_next = 1'b1;
                                    state_next      = ST_HOLD;
                                end
                                else
                                begin
                                    pend_valid_next  = 1'b1;
                                    pend_letter_next = txt_letter;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                walk_next = walk_reg + LETTER_W'(1);
                if (walk_reg == LETTER_Z)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOK:
            begin
                if (sq_res.valid)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            filler_reg      <= FILLER_RESET;
            used_reg        <= '0;
            fill_count_reg  <= '0;
            walk_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
            res_twice_reg   <= 1'b0;
            res_status_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            fill_count_reg  <= fill_count_next;
            walk_reg        <= walk_next;
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
            res_twice_reg   <= res_twice_next;
            res_status_reg  <= res_status_next;
            if (cfg_valid && cfg_ready)
            begin
                filler_reg <= cfg_data;
            end
            // a doubled-letter tail repeats the same pair as a second beat
            if (load)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= !res_twice_reg;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                if (out_last_reg)
                begin
                    out_valid_reg <= 1'b0;
                end
                else
                begin
                    out_last_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_a_reg      <= res_status_reg ? '0 : sq_res.first;
            out_b_reg      <= res_status_reg ? '0 : sq_res.second;
            out_status_reg <= res_status_reg;
        end
    end

    pfc_square u_square
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (sq_wr),
        .req   (sq_req),
        .res   (sq_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_b_reg, out_a_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    a_res_in_look: assert property (@(posedge clk) disable iff (!rst_n)
        sq_res.valid |-> state_reg == ST_LOOK)
        else $error("square result outside lookup");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FULL_COUNT)
        else $error("fill count past square size");

    a_repeat_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && m_axis_tlast && $stable(m_axis_tdata))
        else $error("second beat of doubled tail missing");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0 && m_axis_tlast)
        else $error("status beat carries data");

endmodule

@@ sim/tb_playfair_digraph_cipher_core.sv @@
// ----------------------------------------------------------------------------
// tb_playfair_digraph_cipher_core
// Self-checking bench for the Playfair core. A short directed table is run
// first. Random key builds and text runs follow, one phase per filler
// setting. Every output beat is compared in order with the expected pairs:
// typed directed rows give their own, the bench's square model the rest.
// ----------------------------------------------------------------------------
module tb_playfair_digraph_cipher_core;
    import pfc_pkg::*;

    localparam int          LIMIT_CYCLES = 1000000;
    localparam int          DRAIN_CYCLES = 40;     // complete-key walk plus pair pipeline
    localparam int          PHASE_ITEMS  = 200;
    localparam int          NUM_PHASES   = 8;
    localparam int          N_DIR        = 29;
    localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
    localparam logic [2:0]  OP_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [4:0] first;
        logic [4:0] second;
        logic       status;
        logic       tl;
    } pair_t;

    typedef struct {
        logic [2:0] op;
        logic [4:0] ltr;
        bit         tl;
        bit         typed;   // expectation taken from this row, not the model
        int         nres;
        logic [4:0] f;
        logic [4:0] s;
        logic       st;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    // square model
    logic [4:0]  sq [SQ_CELLS];
    int          pos [26];
    bit          used [26];
    int          fill_cnt;
    bit          pend_v;
    logic [4:0]  pend_l;
    logic [4:0]  filler_reg;

    pair_t       step_pairs[$];    // results of the beat just taken
    pair_t       due_pairs[$];     // results still to arrive
    pair_t       want_pair;
    int          errors = 0;
    int          cycles = 0;
    int          sent_items = 0;
    bit          src_idle_on = 1'b0;
    bit          snk_idle_on = 1'b0;
    bit          quiet = 1'b0;

    dir_row_t dir_rows [N_DIR] = '{
        // key incomplete: text is dropped
        '{OP_ENCRYPT,  5'd0,     1, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_DECRYPT,  LETTER_Z, 1, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_SPARE_HI, 5'd31,    1, 1, 0, 5'd0, 5'd0, 1'b0},
        // empty key -> alphabet square
        '{OP_COMPLETE, 5'd0,     0, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_ENCRYPT,  5'd0,     0, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_ENCRYPT,  5'd1,     1, 1, 1, 5'd1, 5'd2, 1'b0},
        '{OP_DECRYPT,  5'd31,    1, 1, 0, 5'd0, 5'd0, 1'b0},
        // lone ciphertext letter flagged
        '{OP_DECRYPT,  LETTER_Z, 1, 1, 1, 5'd0, 5'd0, 1'b1},
        '{OP_CLEAR,    5'd0,     0, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_KEY,      5'd31,    0, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_KEY,      LETTER_J, 0, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_KEY,      5'd15,    0, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_KEY,      5'd11,    0, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_KEY,      5'd0,     0, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_KEY,      5'd15,    0, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_KEY,      5'd24,    0, 1, 0, 5'd0, 5'd0, 1'b0},
        '{OP_COMPLETE, 5'd0,     0, 1, 0, 5'd0, 5'd0, 1'b0},
        // J folds to I, then a doubled I, then an odd tail
        '{OP_ENCRYPT,  LETTER_J, 0, 0, 0, 5'd0, 5'd0, 1'b0},
        '{OP_ENCRYPT,  LETTER_I, 0, 0, 0, 5'd0, 5'd0, 1'b0},
        '{OP_ENCRYPT,  LETTER_Z, 1, 0, 0, 5'd0, 5'd0, 1'b0},
        '{OP_ENCRYPT,  5'd16,    1, 0, 0, 5'd0, 5'd0, 1'b0},
        '{OP_DECRYPT,  5'd0,     0, 0, 0, 5'd0, 5'd0, 1'b0},
        '{OP_DECRYPT,  LETTER_J, 1, 0, 0, 5'd0, 5'd0, 1'b0},
        // pending letter handed across text operations
        '{OP_ENCRYPT,  5'd22,    0, 0, 0, 5'd0, 5'd0, 1'b0},
        '{OP_DECRYPT,  LETTER_X, 1, 0, 0, 5'd0, 5'd0, 1'b0},
        '{OP_DECRYPT,  5'd7,     0, 0, 0, 5'd0, 5'd0, 1'b0},
        // double on the last letter gives two pairs
        '{OP_ENCRYPT,  5'd7,     1, 0, 0, 5'd0, 5'd0, 1'b0},
        // letter equal to the filler
        '{OP_ENCRYPT,  LETTER_X, 1, 0, 0, 5'd0, 5'd0, 1'b0},
        '{OP_ENCRYPT,  5'd31,    0, 0, 0, 5'd0, 5'd0, 1'b0}
    };

    playfair_digraph_cipher_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb_playfair_digraph_cipher_core: done, errors");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        errors++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // ---------------- square model ----------------

    function automatic void place_letter(input int l);
        if (l > LETTER_Z || l == LETTER_J || used[l] || fill_cnt >= SQ_CELLS)
            return;
        sq[fill_cnt] = 5'(l);
        pos[l]       = fill_cnt;
        used[l]      = 1'b1;
        fill_cnt++;
    endfunction

    function automatic pair_t map_pair(input logic [4:0] a, input logic [4:0] b,
                                       input bit dec);
        int    r1, c1, r2, c2, sh;
        pair_t p;
        r1 = pos[a] / SQ_SIDE;
        c1 = pos[a] % SQ_SIDE;
        r2 = pos[b] / SQ_SIDE;
        c2 = pos[b] % SQ_SIDE;
        sh = dec ? SQ_SIDE - 1 : 1;
        p  = '0;
        if (r1 == r2)
        begin
            p.first  = sq[r1 * SQ_SIDE + (c1 + sh) % SQ_SIDE];
            p.second = sq[r2 * SQ_SIDE + (c2 + sh) % SQ_SIDE];
        end
        else if (c1 == c2)
        begin
            p.first  = sq[((r1 + sh) % SQ_SIDE) * SQ_SIDE + c1];
            p.second = sq[((r2 + sh) % SQ_SIDE) * SQ_SIDE + c2];
        end
        else
        begin
            p.first  = sq[r1 * SQ_SIDE + c2];
            p.second = sq[r2 * SQ_SIDE + c1];
        end
        return p;
    endfunction

    function automatic void playfair_step(input logic [2:0] op, input logic [4:0] ltr,
                                          input bit tl);
        logic [4:0] l, f;
        pair_t      p;
        step_pairs.delete();
        l = ltr;
        case (op)
            OP_CLEAR:
            begin
                used     = '{default: 1'b0};
                fill_cnt = 0;
                pend_v   = 1'b0;
                pend_l   = '0;
                return;
            end
            OP_KEY:
            begin
                place_letter(l);
                return;
            end
            OP_COMPLETE:
            begin
                for (int i = 0; i <= LETTER_Z; i++)
                    place_letter(i);
                return;
            end
            OP_ENCRYPT, OP_DECRYPT: ;
            default: return;
        endcase
        if (fill_cnt < SQ_CELLS || l > LETTER_Z)
            return;
        if (l == LETTER_J)
            l = LETTER_I;
        f = (filler_reg > LETTER_Z) ? LETTER_Z : filler_reg;
        if (f == LETTER_J)
            f = LETTER_I;
        if (op == OP_ENCRYPT)
        begin
            if (pend_v)
            begin
                if (pend_l == l)
                    step_pairs.push_back(map_pair(l, f, 1'b0));
                else
                begin
                    step_pairs.push_back(map_pair(pend_l, l, 1'b0));
                    pend_v = 1'b0;
                end
            end
            else
            begin
                pend_v = 1'b1;
                pend_l = l;
            end
            if (tl && pend_v)
            begin
                step_pairs.push_back(map_pair(pend_l, f, 1'b0));
                pend_v = 1'b0;
            end
        end
        else
        begin
            if (pend_v)
            begin
                step_pairs.push_back(map_pair(pend_l, l, 1'b1));
                pend_v = 1'b0;
            end
            else if (tl)
            begin
                p        = '0;
                p.status = 1'b1;
                step_pairs.push_back(p);
            end
            else
            begin
                pend_v = 1'b1;
                pend_l = l;
            end
        end
        if (!pend_v)
            pend_l = '0;
        if (step_pairs.size() > 0)
            step_pairs[step_pairs.size() - 1].tl = 1'b1;
    endfunction

    // ---------------- drivers ----------------

    // drive one input beat, wait for acceptance, run the model on it
    task automatic send_beat(input logic [2:0] op, input logic [4:0] ltr, input bit tl);
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ltr};
        s_axis_tuser  <= op;
        s_axis_tlast  <= tl;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        playfair_step(op, ltr, tl);
    endtask

    task automatic send_checked(input logic [2:0] op, input logic [4:0] ltr, input bit tl);
        send_beat(op, ltr, tl);
        foreach (step_pairs[i])
            due_pairs.push_back(step_pairs[i]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_filler(input logic [4:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        filler_reg = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic build_key();
        int n;
        n = $urandom_range(0, 30);
        send_checked(OP_CLEAR, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        for (int k = 0; k < n; k++)
            send_checked(OP_KEY, ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                              : 5'($urandom_range(0, 25)), 1'b0);
        // text before completion is dropped
        if ($urandom_range(0, 3) == 0)
            send_checked(OP_ENCRYPT + 3'($urandom_range(0, 1)),
                         5'($urandom_range(0, 25)), 1'($urandom_range(0, 1)));
        send_checked(OP_COMPLETE, 5'($urandom_range(0, 31)), 1'b0);
        sent_items += n + 2;
    endtask

    task automatic text_run();
        logic [2:0] op;
        logic [4:0] ltr, prev;
        int         len, pick;
        bit         mixed, drop_last;
        op        = $urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT;
        mixed     = ($urandom_range(0, 9) == 0);
        drop_last = ($urandom_range(0, 9) == 0);
        len       = $urandom_range(1, 10);
        prev      = 5'($urandom_range(0, 25));
        if (!quiet)
        begin
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
        end
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                ltr = prev;
            else if (pick < 35)
                ltr = filler_reg;
            else
                ltr = 5'($urandom_range(0, 25));
            if (mixed)
                op = $urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT;
            send_checked(op, ltr, (k == len - 1) && !drop_last);
            prev = ltr;
        end
        sent_items += len;
    endtask

    // beats the block should ignore or that change nothing once the key is full
    task automatic noise_beat();
        case ($urandom_range(0, 3))
            0: send_checked(OP_KEY, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            1: send_checked(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                            5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            2: send_checked(OP_ENCRYPT + 3'($urandom_range(0, 1)),
                            5'($urandom_range(26, 31)), 1'($urandom_range(0, 1)));
            default: send_checked(OP_COMPLETE, 5'($urandom_range(0, 31)),
                                  1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic run_phase(input bit fresh_key);
        int start, pick;
        start = sent_items;
        if (fresh_key)
            build_key();
        while (sent_items - start < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                noise_beat();
            else if (pick < 11)
                build_key();
            else
                text_run();
        end
    endtask

    // ---------------- sink and checker ----------------

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (snk_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_pairs.size() == 0)
                flag_mismatch($sformatf("unexpected beat data=%h user=%b last=%b",
                                        m_axis_tdata, m_axis_tuser, m_axis_tlast));
            else
            begin
                want_pair = due_pairs.pop_front();
                if (m_axis_tdata[4:0] !== want_pair.first)
                    flag_mismatch($sformatf("first_out %0d, want %0d",
                                            m_axis_tdata[4:0], want_pair.first));
                if (m_axis_tdata[9:5] !== want_pair.second)
                    flag_mismatch($sformatf("second_out %0d, want %0d",
                                            m_axis_tdata[9:5], want_pair.second));
                if (m_axis_tdata[15:10] !== 6'd0)
                    flag_mismatch($sformatf("tdata pad bits %h", m_axis_tdata[15:10]));
                if (m_axis_tuser[0] !== want_pair.status)
                    flag_mismatch($sformatf("status %b, want %b",
                                            m_axis_tuser[0], want_pair.status));
                if (m_axis_tlast !== want_pair.tl)
                    flag_mismatch($sformatf("last_of_run %b, want %b",
                                            m_axis_tlast, want_pair.tl));
            end
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin
        pair_t      p;
        logic [4:0] filler_pick;
        used       = '{default: 1'b0};
        pos        = '{default: 0};
        sq         = '{default: 5'd0};
        fill_cnt   = 0;
        pend_v     = 1'b0;
        pend_l     = '0;
        filler_reg = FILLER_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i].op, dir_rows[i].ltr, dir_rows[i].tl);
            if (dir_rows[i].typed)
            begin
                if (dir_rows[i].nres > 0)
                begin
                    p.first  = dir_rows[i].f;
                    p.second = dir_rows[i].s;
                    p.status = dir_rows[i].st;
                    p.tl     = 1'b1;
                    due_pairs.push_back(p);
                end
            end
            else
            begin
                foreach (step_pairs[j])
                    due_pairs.push_back(step_pairs[j]);
            end
        end
        sent_items = N_DIR;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: filler_pick = 5'd0;
                1: filler_pick = 5'd31;
                2: filler_pick = LETTER_J;
                3: filler_pick = LETTER_Z;
                4: filler_pick = LETTER_X;
                default: filler_pick = 5'($urandom_range(0, 31));
            endcase
            set_filler(filler_pick);
            // final phase runs with both sides always ready
            quiet = (ph == NUM_PHASES - 1);
            if (quiet)
            begin
                src_idle_on = 1'b0;
                snk_idle_on = 1'b0;
            end
            run_phase(ph == 0 || $urandom_range(0, 2) == 0);
        end

        drain();
        if (errors == 0)
            $display("tb_playfair_digraph_cipher_core: done, clean");
        else
            $display("tb_playfair_digraph_cipher_core: done, errors");
        $finish;
    end

endmodule
